// ----- design/scc_pkg.sv -----
// Package for the spectral color classifier: widths, register and color codes,
// reset values, the divide-by-ten constant and the argmax helper.
// Depends on nothing; the top level, the checker and the testbench refer to it.
`default_nettype none

package scc_pkg;

  // Port widths of the input and result fields.
  localparam int unsigned CHAN_W      = 16;
  localparam int unsigned RED_SUM_W   = 17;
  localparam int unsigned GREEN_SUM_W = 17;
  localparam int unsigned BLUE_SUM_W  = 18;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned TOTAL_MIN_W = 19;

  // Default channel resolution.
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values.
  localparam logic [PCT_W-1:0]       RED_PCT_MIN_RST   = 7'd38;
  localparam logic [PCT_W-1:0]       GREEN_PCT_MIN_RST = 7'd26;
  localparam logic [PCT_W-1:0]       BLUE_PCT_MIN_RST  = 7'd30;
  localparam logic [TOTAL_MIN_W-1:0] TOTAL_MIN_RST     = 19'd2000;

  // floor(p/10) = (p * DIV10_MAGIC) >> DIV10_SHIFT holds exactly for p < 2**21.
  // DIV10_MAGIC is ceil(2**24 / 10).
  localparam int unsigned      DIV10_MAGIC_W = 21;
  localparam int unsigned      DIV10_SHIFT   = 24;
  localparam logic [20:0]      DIV10_MAGIC   = 21'd1677722;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_RED_PCT_MIN   = 2'd0,
    REG_GREEN_PCT_MIN = 2'd1,
    REG_BLUE_PCT_MIN  = 2'd2,
    REG_TOTAL_MIN     = 2'd3
  } reg_idx_e;

  // Decided color.
  typedef enum logic [1:0] {
    HUE_RED   = 2'd0,
    HUE_GREEN = 2'd1,
    HUE_BLUE  = 2'd2
  } color_e;

  // Side information that travels next to the percentage dividers.
  typedef struct packed {
    logic [RED_SUM_W-1:0]   red_sum;
    logic [GREEN_SUM_W-1:0] green_sum;
    logic [BLUE_SUM_W-1:0]  blue_sum;
    logic                   low_total;
  } meta_t;

  // Largest of three values; ties go red, then green, then blue.
  function automatic color_e argmax3(input logic [BLUE_SUM_W-1:0] r,
                                     input logic [BLUE_SUM_W-1:0] g,
                                     input logic [BLUE_SUM_W-1:0] b);
    color_e res;
    if (r >= g && r >= b) begin
      res = HUE_RED;
    end else if (g >= r && g >= b) begin
      res = HUE_GREEN;
    end else begin
      res = HUE_BLUE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- design/scc_pct_div.sv -----
// Pipelined restoring divider for the percentage lanes: one quotient bit per
// register stage, quotient known to fit in QuoW bits. Uses no package items.
`default_nettype none

module scc_pct_div #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 19,
  parameter int unsigned QuoW = 7
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output      logic [QuoW-1:0] quo_o
);

  // Stage registers; the last stage keeps only its quotient.
  logic [NumW-1:0] rem_q [QuoW-1];
  logic [DenW-1:0] den_q [QuoW-1];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] trial;
    logic            fits;
    logic [NumW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Try to take the divisor, shifted to this stage's quotient bit.
    always_comb begin
      trial = NumW'(den_in) << (QuoW - 1 - k);
      fits  = (rem_in >= trial);
      rem_d = fits ? (rem_in - trial) : rem_in;
      quo_d = quo_in;
      quo_d[QuoW-1-k] = fits;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_d;
      end
    end

    if (k < QuoW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

`default_nettype wire

// ----- design/spectral_color_classifier_unit.sv -----
// Spectral color classifier top level: band sums, percentages and decision.
// Depends on scc_pkg and scc_pct_div.
//
// Usage:
//   An input transaction carries six channel counts (chan_*_i) under
//   in_valid_i / in_stall_o; a result transaction carries the decided color,
//   the three band sums and the three percentages under out_valid_o /
//   out_stall_i. A transaction completes on a rising edge where valid is high
//   and stall is low.
//   From input to result, three stages form the sums, the divide by ten and
//   the total, seven stages run the percentage dividers (one quotient bit
//   each), and one stage decides and holds the result. One transaction is
//   accepted every cycle while the receiver does not stall a valid result.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and loads the register defaults: red 38,
//   green 26, blue 30 percent and a minimum total of 2000. pready is always
//   high. The user writes registers over the APB port at byte addresses 0, 4,
//   8, 12 while no transaction is in flight; the block does not enforce it.
`default_nettype none

module spectral_color_classifier_unit #(
  parameter int unsigned ChannelBits = scc_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [scc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [scc_pkg::APB_DATA_W-1:0]      pwdata,
  output      logic [scc_pkg::APB_DATA_W-1:0]      prdata,
  output      logic                                pready,
  // Input channel.
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_445_i,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_480_i,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_515_i,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_555_i,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_630_i,
  input  wire logic [scc_pkg::CHAN_W-1:0]          chan_680_i,
  // Result channel.
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [1:0]                          color_code_o,
  output      logic [scc_pkg::RED_SUM_W-1:0]       red_sum_o,
  output      logic [scc_pkg::GREEN_SUM_W-1:0]     green_sum_o,
  output      logic [scc_pkg::BLUE_SUM_W-1:0]      blue_sum_o,
  output      logic [scc_pkg::PCT_W-1:0]           red_pct_o,
  output      logic [scc_pkg::PCT_W-1:0]           green_pct_o,
  output      logic [scc_pkg::PCT_W-1:0]           blue_pct_o
);

  // Internal widths follow from the channel resolution.
  localparam int unsigned SumW   = ChannelBits + 1;          // pair sum
  localparam int unsigned P13W   = SumW + 4;                 // 13 * pair sum
  localparam int unsigned ProdW  = P13W + scc_pkg::DIV10_MAGIC_W;
  localparam int unsigned BlueW  = SumW + 1;                 // 1.3 * pair sum
  localparam int unsigned TotW   = SumW + 2;                 // below 2.95 * 2**SumW
  localparam int unsigned NumW   = TotW + scc_pkg::PCT_W;    // 100 * total
  localparam int unsigned PctW   = scc_pkg::PCT_W;
  localparam int unsigned Stages = 3 + PctW;                 // stages before output

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [PctW-1:0]                 red_min_q, green_min_q, blue_min_q;
  logic [scc_pkg::TOTAL_MIN_W-1:0] total_min_q;
  logic                            cfg_wr;
  scc_pkg::reg_idx_e               cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = scc_pkg::reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_min_q   <= scc_pkg::RED_PCT_MIN_RST;
      green_min_q <= scc_pkg::GREEN_PCT_MIN_RST;
      blue_min_q  <= scc_pkg::BLUE_PCT_MIN_RST;
      total_min_q <= scc_pkg::TOTAL_MIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        scc_pkg::REG_RED_PCT_MIN:   red_min_q   <= pwdata[PctW-1:0];
        scc_pkg::REG_GREEN_PCT_MIN: green_min_q <= pwdata[PctW-1:0];
        scc_pkg::REG_BLUE_PCT_MIN:  blue_min_q  <= pwdata[PctW-1:0];
        scc_pkg::REG_TOTAL_MIN:     total_min_q <= pwdata[scc_pkg::TOTAL_MIN_W-1:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      scc_pkg::REG_RED_PCT_MIN:   prdata = scc_pkg::APB_DATA_W'(red_min_q);
      scc_pkg::REG_GREEN_PCT_MIN: prdata = scc_pkg::APB_DATA_W'(green_min_q);
      scc_pkg::REG_BLUE_PCT_MIN:  prdata = scc_pkg::APB_DATA_W'(blue_min_q);
      scc_pkg::REG_TOTAL_MIN:     prdata = scc_pkg::APB_DATA_W'(total_min_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves when the output register can move.
  logic              adv;
  logic [Stages-1:0] vld_q;
  logic              out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Stages-2:0], in_valid_i};
      out_valid_q <= vld_q[Stages-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pair sums and 13 times the red and blue pairs.
  logic [SumW-1:0] sum_b, sum_r;
  logic [P13W-1:0] p13b_q, p13r_q;
  logic [SumW-1:0] grn1_q;

  assign sum_b = SumW'(chan_445_i[ChannelBits-1:0]) + SumW'(chan_480_i[ChannelBits-1:0]);
  assign sum_r = SumW'(chan_630_i[ChannelBits-1:0]) + SumW'(chan_680_i[ChannelBits-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p13b_q <= (P13W'(sum_b) << 3) + (P13W'(sum_b) << 2) + P13W'(sum_b);
      p13r_q <= (P13W'(sum_r) << 3) + (P13W'(sum_r) << 2) + P13W'(sum_r);
      grn1_q <= SumW'(chan_515_i[ChannelBits-1:0]) + SumW'(chan_555_i[ChannelBits-1:0]);
    end
  end

  // Stage 2: divide by ten through the reciprocal; red halves once more.
  logic [ProdW-1:0] prod_b, prod_r;
  logic [BlueW-1:0] blu2_q;
  logic [SumW-1:0]  red2_q, grn2_q;
  logic [SumW-1:0]  grn2_d;

  assign prod_b = ProdW'(p13b_q) * ProdW'(scc_pkg::DIV10_MAGIC);
  assign prod_r = ProdW'(p13r_q) * ProdW'(scc_pkg::DIV10_MAGIC);
  assign grn2_d = grn1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      blu2_q <= BlueW'(prod_b >> scc_pkg::DIV10_SHIFT);
      red2_q <= SumW'(prod_r >> (scc_pkg::DIV10_SHIFT + 1));
      grn2_q <= grn2_d;
    end
  end

  // Stage 3: total, low-light flag and the scaled numerators.
  logic [TotW-1:0]      total;
  logic                 low_total;
  logic [TotW-1:0]      tot3_q;
  logic [NumW-1:0]      num_r_q, num_g_q, num_b_q;
  scc_pkg::meta_t       meta_q [PctW+1];

  assign total     = TotW'(red2_q) + TotW'(grn2_q) + TotW'(blu2_q);
  assign low_total = (scc_pkg::TOTAL_MIN_W'(total) < total_min_q) || (total == '0);

  // Multiply by 100 as 64 + 32 + 4.
  function automatic logic [NumW-1:0] times100(input logic [TotW-1:0] x);
    logic [NumW-1:0] w;
    w = NumW'(x);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tot3_q            <= total;
      num_r_q           <= times100(TotW'(red2_q));
      num_g_q           <= times100(TotW'(grn2_q));
      num_b_q           <= times100(TotW'(blu2_q));
      meta_q[0].red_sum   <= scc_pkg::RED_SUM_W'(red2_q);
      meta_q[0].green_sum <= scc_pkg::GREEN_SUM_W'(grn2_q);
      meta_q[0].blue_sum  <= scc_pkg::BLUE_SUM_W'(blu2_q);
      meta_q[0].low_total <= low_total;
      for (int i = 1; i <= PctW; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Percentage dividers, one lane per color.
  logic [PctW-1:0] quo_r, quo_g, quo_b;

  scc_pct_div #(.NumW(NumW), .DenW(TotW), .QuoW(PctW)) u_div_red (
    .clk_i (clk_i), .en_i (adv), .num_i (num_r_q), .den_i (tot3_q), .quo_o (quo_r)
  );

  scc_pct_div #(.NumW(NumW), .DenW(TotW), .QuoW(PctW)) u_div_green (
    .clk_i (clk_i), .en_i (adv), .num_i (num_g_q), .den_i (tot3_q), .quo_o (quo_g)
  );

  scc_pct_div #(.NumW(NumW), .DenW(TotW), .QuoW(PctW)) u_div_blue (
    .clk_i (clk_i), .en_i (adv), .num_i (num_b_q), .den_i (tot3_q), .quo_o (quo_b)
  );

  // ---------------------------------------------------------------------------
  // Decision and output register.
  scc_pkg::meta_t  meta_d;
  logic [PctW-1:0] rp, gp, bp;
  scc_pkg::color_e color_d;

  assign meta_d = meta_q[PctW];
  assign rp     = meta_d.low_total ? '0 : quo_r;
  assign gp     = meta_d.low_total ? '0 : quo_g;
  assign bp     = meta_d.low_total ? '0 : quo_b;

  always_comb begin
    if (meta_d.low_total) begin
      color_d = scc_pkg::argmax3(scc_pkg::BLUE_SUM_W'(meta_d.red_sum),
                                 scc_pkg::BLUE_SUM_W'(meta_d.green_sum),
                                 meta_d.blue_sum);
    end else if (rp >= red_min_q && rp >= gp && rp >= bp) begin
      color_d = scc_pkg::HUE_RED;
    end else if (gp >= green_min_q && gp >= rp && gp >= bp) begin
      color_d = scc_pkg::HUE_GREEN;
    end else if (bp >= blue_min_q && bp >= rp && bp >= gp) begin
      color_d = scc_pkg::HUE_BLUE;
    end else begin
      color_d = scc_pkg::argmax3(scc_pkg::BLUE_SUM_W'(rp), scc_pkg::BLUE_SUM_W'(gp),
                                 scc_pkg::BLUE_SUM_W'(bp));
    end
  end

  scc_pkg::color_e color_q;
  scc_pkg::meta_t  meta_out_q;
  logic [PctW-1:0] rp_q, gp_q, bp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      color_q    <= color_d;
      meta_out_q <= meta_d;
      rp_q       <= rp;
      gp_q       <= gp;
      bp_q       <= bp;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign color_code_o = color_q;
  assign red_sum_o    = meta_out_q.red_sum;
  assign green_sum_o  = meta_out_q.green_sum;
  assign blue_sum_o   = meta_out_q.blue_sum;
  assign red_pct_o    = rp_q;
  assign green_pct_o  = gp_q;
  assign blue_pct_o   = bp_q;

  // The output flag of the low-light path is not a port.
  logic unused_low;
  assign unused_low = meta_out_q.low_total;

endmodule

`default_nettype wire

// ----- design/scc_checker.sv -----
// Port-level checker for the spectral color classifier, bound to the top level.
// Depends on scc_pkg and spectral_color_classifier_unit.
`default_nettype none

module scc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [1:0]                      color_code_o,
  input wire logic [scc_pkg::RED_SUM_W-1:0]   red_sum_o,
  input wire logic [scc_pkg::GREEN_SUM_W-1:0] green_sum_o,
  input wire logic [scc_pkg::BLUE_SUM_W-1:0]  blue_sum_o,
  input wire logic [scc_pkg::PCT_W-1:0]       red_pct_o,
  input wire logic [scc_pkg::PCT_W-1:0]       green_pct_o,
  input wire logic [scc_pkg::PCT_W-1:0]       blue_pct_o
);

  logic [8:0] pct_total;
  logic       pct_zero;

  assign pct_total = 9'(red_pct_o) + 9'(green_pct_o) + 9'(blue_pct_o);
  assign pct_zero  = (pct_total == 9'd0);

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(color_code_o) &&
      $stable(red_pct_o) && $stable(green_pct_o) && $stable(blue_pct_o) &&
      $stable(red_sum_o) && $stable(green_sum_o) && $stable(blue_sum_o))
    else $error("stalled result changed");

  // Floored percentages of one total lose less than three points together.
  a_pct_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pct_zero |-> pct_total >= 9'd98 && pct_total <= 9'd100)
    else $error("percentages do not add up");

  // In low light a red decision needs a red sum no smaller than the others (ties to red).
  a_low_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pct_zero && color_code_o == scc_pkg::HUE_RED |->
      18'(red_sum_o) >= 18'(green_sum_o) && 18'(red_sum_o) >= blue_sum_o)
    else $error("low-light red decision against the sums");

  // The decided color is always one of the three codes.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> color_code_o == scc_pkg::HUE_RED ||
      color_code_o == scc_pkg::HUE_GREEN || color_code_o == scc_pkg::HUE_BLUE)
    else $error("color code out of range");

endmodule

bind spectral_color_classifier_unit scc_checker u_scc_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_spectral_color_classifier_unit.sv -----
// Self-checking testbench for spectral_color_classifier_unit: directed and random samples
// with random idle and stall bursts, checked against a predictor of the band math.
// Depends on scc_pkg and the RTL of the block; reads no files.

module tb_spectral_color_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // One sample of six channel counts.
  typedef struct {
    logic [scc_pkg::CHAN_W-1:0] c445;
    logic [scc_pkg::CHAN_W-1:0] c480;
    logic [scc_pkg::CHAN_W-1:0] c515;
    logic [scc_pkg::CHAN_W-1:0] c555;
    logic [scc_pkg::CHAN_W-1:0] c630;
    logic [scc_pkg::CHAN_W-1:0] c680;
  } sample_t;

  // One predicted classification.
  typedef struct {
    scc_pkg::color_e                 color;
    logic [scc_pkg::RED_SUM_W-1:0]   red_sum;
    logic [scc_pkg::GREEN_SUM_W-1:0] green_sum;
    logic [scc_pkg::BLUE_SUM_W-1:0]  blue_sum;
    logic [scc_pkg::PCT_W-1:0]       red_pct;
    logic [scc_pkg::PCT_W-1:0]       green_pct;
    logic [scc_pkg::PCT_W-1:0]       blue_pct;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [scc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [scc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [scc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [scc_pkg::CHAN_W-1:0] chan_445 = '0;
  logic [scc_pkg::CHAN_W-1:0] chan_480 = '0;
  logic [scc_pkg::CHAN_W-1:0] chan_515 = '0;
  logic [scc_pkg::CHAN_W-1:0] chan_555 = '0;
  logic [scc_pkg::CHAN_W-1:0] chan_630 = '0;
  logic [scc_pkg::CHAN_W-1:0] chan_680 = '0;

  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      color_code;
  logic [scc_pkg::RED_SUM_W-1:0]   red_sum;
  logic [scc_pkg::GREEN_SUM_W-1:0] green_sum;
  logic [scc_pkg::BLUE_SUM_W-1:0]  blue_sum;
  logic [scc_pkg::PCT_W-1:0]       red_pct;
  logic [scc_pkg::PCT_W-1:0]       green_pct;
  logic [scc_pkg::PCT_W-1:0]       blue_pct;

  // Predictor copy of the registers.
  logic [scc_pkg::PCT_W-1:0]       red_thr   = scc_pkg::RED_PCT_MIN_RST;
  logic [scc_pkg::PCT_W-1:0]       green_thr = scc_pkg::GREEN_PCT_MIN_RST;
  logic [scc_pkg::PCT_W-1:0]       blue_thr  = scc_pkg::BLUE_PCT_MIN_RST;
  logic [scc_pkg::TOTAL_MIN_W-1:0] total_floor = scc_pkg::TOTAL_MIN_RST;

  sample_t  pending_samples[$];
  verdict_t predicted_verdicts[$];

  int n_samples_queued = 0;
  int n_in_driven = 0;
  int n_in_accepted = 0;
  int n_errors = 0;

  // Idle burst likelihood in percent per decision, set per phase.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int snd_gap = 0;
  int rcv_gap = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;

  spectral_color_classifier_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .chan_445_i   (chan_445),
    .chan_480_i   (chan_480),
    .chan_515_i   (chan_515),
    .chan_555_i   (chan_555),
    .chan_630_i   (chan_630),
    .chan_680_i   (chan_680),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .color_code_o (color_code),
    .red_sum_o    (red_sum),
    .green_sum_o  (green_sum),
    .blue_sum_o   (blue_sum),
    .red_pct_o    (red_pct),
    .green_pct_o  (green_pct),
    .blue_pct_o   (blue_pct)
  );

  always #1 clk_i = ~clk_i;

  // Strongest of three bands; on a tie the earlier band in red, green, blue order wins.
  function automatic scc_pkg::color_e strongest_band(input int unsigned r,
                                                     input int unsigned g,
                                                     input int unsigned b);
    scc_pkg::color_e c;
    c = scc_pkg::HUE_RED;
    if (g > r) c = scc_pkg::HUE_GREEN;
    if (c == scc_pkg::HUE_RED && b > r) c = scc_pkg::HUE_BLUE;
    if (c == scc_pkg::HUE_GREEN && b > g) c = scc_pkg::HUE_BLUE;
    return c;
  endfunction

  // Band sums, percentages and the decided color for one sample.
  function automatic verdict_t predict_color(input sample_t s);
    int unsigned r, g, b, tot, rp, gp, bp;
    verdict_t v;
    b   = (32'd13 * (32'(s.c445) + 32'(s.c480))) / 32'd10;
    g   = 32'(s.c515) + 32'(s.c555);
    r   = (32'd13 * (32'(s.c630) + 32'(s.c680))) / 32'd20;
    tot = r + g + b;
    rp  = 0;
    gp  = 0;
    bp  = 0;
    if (tot < 32'(total_floor) || tot == 0) begin
      v.color = strongest_band(r, g, b);
    end else begin
      rp = (r * 100) / tot;
      gp = (g * 100) / tot;
      bp = (b * 100) / tot;
      if (rp >= red_thr && rp >= gp && rp >= bp) begin
        v.color = scc_pkg::HUE_RED;
      end else if (gp >= green_thr && gp >= rp && gp >= bp) begin
        v.color = scc_pkg::HUE_GREEN;
      end else if (bp >= blue_thr && bp >= rp && bp >= gp) begin
        v.color = scc_pkg::HUE_BLUE;
      end else begin
        v.color = strongest_band(rp, gp, bp);
      end
    end
    v.red_sum   = r[scc_pkg::RED_SUM_W-1:0];
    v.green_sum = g[scc_pkg::GREEN_SUM_W-1:0];
    v.blue_sum  = b[scc_pkg::BLUE_SUM_W-1:0];
    v.red_pct   = rp[scc_pkg::PCT_W-1:0];
    v.green_pct = gp[scc_pkg::PCT_W-1:0];
    v.blue_pct  = bp[scc_pkg::PCT_W-1:0];
    return v;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Input driver: holds a sample until it is taken, then idles or offers the next one.
  always @(negedge clk_i) begin : sample_driver
    sample_t s;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (n_in_driven == n_in_accepted) begin
      if (snd_gap > 0) begin
        snd_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < snd_idle_pct) begin
        snd_gap = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else begin
        s = pending_samples.pop_front();
        chan_445 <= s.c445;
        chan_480 <= s.c480;
        chan_515 <= s.c515;
        chan_555 <= s.c555;
        chan_630 <= s.c630;
        chan_680 <= s.c680;
        in_valid <= 1'b1;
        n_in_driven++;
      end
    end
  end

  // Result receiver stall: random bursts plus one long hold that backs up the pipeline.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && n_in_accepted >= 160) begin
      long_hold_done = 1'b1;
      long_hold = 79;
      out_stall <= 1'b1;
    end else if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < rcv_idle_pct) begin
      rcv_gap = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts each accepted sample and checks each accepted result.
  always @(posedge clk_i) begin : result_monitor
    sample_t  s;
    verdict_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        s.c445 = chan_445;
        s.c480 = chan_480;
        s.c515 = chan_515;
        s.c555 = chan_555;
        s.c630 = chan_630;
        s.c680 = chan_680;
        predicted_verdicts.push_back(predict_color(s));
        n_in_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (predicted_verdicts.size() == 0) begin
          $error("result transaction with no sample outstanding");
          n_errors++;
        end else begin
          want = predicted_verdicts.pop_front();
          compare_field("color_code", want.color, color_code);
          compare_field("red_sum", want.red_sum, red_sum);
          compare_field("green_sum", want.green_sum, green_sum);
          compare_field("blue_sum", want.blue_sum, blue_sum);
          compare_field("red_pct", want.red_pct, red_pct);
          compare_field("green_pct", want.green_pct, green_pct);
          compare_field("blue_pct", want.blue_pct, blue_pct);
        end
      end
    end
  end

  // APB write: setup then access cycle; junk above the register width must be dropped.
  task automatic write_reg(input scc_pkg::reg_idx_e idx, input int unsigned value,
                           input int unsigned width);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value | ($urandom << width);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      scc_pkg::REG_RED_PCT_MIN:   red_thr = value[scc_pkg::PCT_W-1:0];
      scc_pkg::REG_GREEN_PCT_MIN: green_thr = value[scc_pkg::PCT_W-1:0];
      scc_pkg::REG_BLUE_PCT_MIN:  blue_thr = value[scc_pkg::PCT_W-1:0];
      scc_pkg::REG_TOTAL_MIN:     total_floor = value[scc_pkg::TOTAL_MIN_W-1:0];
      default:                    ;
    endcase
  endtask

  task automatic configure(input int unsigned r, input int unsigned g, input int unsigned b,
                           input int unsigned tmin);
    write_reg(scc_pkg::REG_RED_PCT_MIN, r, scc_pkg::PCT_W);
    write_reg(scc_pkg::REG_GREEN_PCT_MIN, g, scc_pkg::PCT_W);
    write_reg(scc_pkg::REG_BLUE_PCT_MIN, b, scc_pkg::PCT_W);
    write_reg(scc_pkg::REG_TOTAL_MIN, tmin, scc_pkg::TOTAL_MIN_W);
  endtask

  task automatic add_sample(input int unsigned c445, input int unsigned c480,
                            input int unsigned c515, input int unsigned c555,
                            input int unsigned c630, input int unsigned c680);
    sample_t s;
    s.c445 = c445[scc_pkg::CHAN_W-1:0];
    s.c480 = c480[scc_pkg::CHAN_W-1:0];
    s.c515 = c515[scc_pkg::CHAN_W-1:0];
    s.c555 = c555[scc_pkg::CHAN_W-1:0];
    s.c630 = c630[scc_pkg::CHAN_W-1:0];
    s.c680 = c680[scc_pkg::CHAN_W-1:0];
    pending_samples.push_back(s);
    n_samples_queued++;
  endtask

  // Random samples: full range, dim light near the total floor, one dominant band,
  // or three bands of nearly equal weighted strength.
  task automatic add_random(input int n);
    int unsigned base, k;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        1: add_sample($urandom_range(0, 500), $urandom_range(0, 500),
                      $urandom_range(0, 500), $urandom_range(0, 500),
                      $urandom_range(0, 800), $urandom_range(0, 800));
        2: begin
          k = $urandom_range(0, 2);
          add_sample(k == 2 ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                     k == 2 ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                     k == 1 ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                     k == 1 ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                     k == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                     k == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 3000));
        end
        default: begin
          base = $urandom_range(50, 20000);
          add_sample(base * 10 / 13, $urandom_range(0, 20), base, $urandom_range(0, 20),
                     base * 20 / 13, $urandom_range(0, 40));
        end
      endcase
    end
  endtask

  // Waits until every sample is taken and every result is back, then lets the
  // pipeline settle for about its latency.
  task automatic wait_pipeline_empty();
    while (n_in_accepted != n_samples_queued || predicted_verdicts.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (14) @(negedge clk_i);
  endtask

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset thresholds, no idling: band extremes, ties, the total floor and fallbacks.
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(65535, 65535, 65535, 65535, 65535, 65535);
    add_sample(0, 0, 0, 0, 65535, 65535);
    add_sample(0, 0, 65535, 65535, 0, 0);
    add_sample(65535, 65535, 0, 0, 0, 0);
    add_sample(10, 0, 13, 0, 20, 0);
    add_sample(10, 0, 13, 0, 0, 0);
    add_sample(10000, 0, 13000, 0, 20000, 0);
    add_sample(2385, 0, 3200, 0, 5693, 0);
    add_sample(0, 0, 2000, 0, 0, 0);
    add_sample(0, 0, 1999, 0, 0, 0);
    add_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    add_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    wait_pipeline_empty();

    // Zero thresholds and no floor: a dark sample has a zero total.
    configure(0, 0, 0, 0);
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(10, 0, 13, 0, 20, 0);
    add_sample(10000, 0, 13000, 0, 20000, 0);
    add_random(60);
    wait_pipeline_empty();

    // Floor above any reachable total: the raw sums always decide.
    configure(100, 100, 100, 524287);
    snd_idle_pct = 30;
    rcv_idle_pct = 10;
    add_random(60);
    wait_pipeline_empty();

    // Thresholds above one hundred percent: only the fallback argmax can decide.
    configure(127, 127, 127, 0);
    snd_idle_pct = 10;
    rcv_idle_pct = 30;
    add_random(60);
    wait_pipeline_empty();

    configure($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
              $urandom_range(0, 400000));
    snd_idle_pct = 25;
    rcv_idle_pct = 25;
    add_random(80);
    wait_pipeline_empty();

    configure(38, 26, 30, 2000);
    snd_idle_pct = 15;
    rcv_idle_pct = 15;
    add_random(80);
    wait_pipeline_empty();

    // Closing stretch at full rate with no idling on either side.
    configure($urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100),
              $urandom_range(0, 4000));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    add_random(60);
    wait_pipeline_empty();

    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
